>>> rtl/core/gdh_pkg.sv
// ----------------------------------------------------------------------------
// gdh_pkg
// Shared types and constants for the device-side bus handshake engine.
// ----------------------------------------------------------------------------
package gdh_pkg;

   localparam int TIMEOUT_WIDTH = 24;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 24'd200000;

   // command codes carried in the request beat
   typedef enum logic [3:0] {
      OP_TICK      = 4'd0,
      OP_SEND      = 4'd1,
      OP_RECEIVE   = 4'd2,
      OP_ACK       = 4'd3,
      OP_ADDRESS   = 4'd4,
      OP_ACCEPT    = 4'd5,
      OP_REJECT    = 4'd6,
      OP_BEGIN_OUT = 4'd7,
      OP_END_OUT   = 4'd8,
      OP_UNLISTEN  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_BUSY    = 2'd1,
      ST_DONE    = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   // one sampled tick of the bus plus the command
   typedef struct packed {
      logic [3:0] operation;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [7:0] bus_data;
      logic       dav_line;
      logic       nrfd_line;
      logic       ndac_line;
      logic       atn_line;
      logic       eoi_line;
   } item_type;

   typedef struct packed {
      logic       dav_pull_low;
      logic       nrfd_pull_low;
      logic       ndac_pull_low;
      logic       eoi_pull_low;
      logic [7:0] data_drive;
      logic       data_drive_enable;
      status_type status;
      logic [7:0] rx_byte;
      logic       rx_atn_low;
      logic       rx_eoi_low;
      logic       unlistened;
   } result_type;

endpackage

>>> rtl/core/gdh_engine.sv
// ----------------------------------------------------------------------------
// gdh_engine
// Handshake state machine: advances one tick per step and presents the
// resulting line drives and status.
// ----------------------------------------------------------------------------
module gdh_engine
   import gdh_pkg::*;
#(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  item_type                 item,
   input  logic [TIMEOUT_WIDTH-1:0] timeout_ticks,
   output result_type               result
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH : TIMEOUT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam int DR_DAV  = 0;
   localparam int DR_NRFD = 1;
   localparam int DR_NDAC = 2;
   localparam int DR_EOI  = 3;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_SEND_NRFD = 4'd1,
      PH_SEND_NDAC = 4'd2,
      PH_RECV      = 4'd3,
      PH_ACK       = 4'd4,
      PH_ADDR      = 4'd5,
      PH_ACCEPT    = 4'd6,
      PH_REJECT    = 4'd7,
      PH_BOUT_ATN  = 4'd8,
      PH_BOUT_NDAC = 4'd9
   } phase_type;

   phase_type              phase_ff,     phase_in;
   logic [COUNT_WIDTH-1:0] wait_ff,      wait_in;
   logic                   held_last_ff, held_last_in;
   logic [3:0]             drv_ff,       drv_in;
   logic [7:0]             data_out_ff,  data_out_in;
   logic                   data_oe_ff,   data_oe_in;
   logic [7:0]             rx_ff,        rx_in;
   logic                   atn_low_ff,   atn_low_in;
   logic                   eoi_low_ff,   eoi_low_in;
   logic                   unl_ff,       unl_in;
   status_type             status;

   always_comb begin
      logic expired;
      logic [COUNT_WIDTH-1:0] wait_bump;

      phase_in     = phase_ff;
      wait_in      = wait_ff;
      held_last_in = held_last_ff;
      drv_in       = drv_ff;
      data_out_in  = data_out_ff;
      data_oe_in   = data_oe_ff;
      rx_in        = rx_ff;
      atn_low_in   = atn_low_ff;
      eoi_low_in   = eoi_low_ff;
      unl_in       = unl_ff;
      status       = ST_IDLE;

      // command intake while idle
      if (phase_ff == PH_IDLE) begin
         wait_in = '0;
         case (op_type'(item.operation))
            OP_SEND: begin
               held_last_in = item.tx_last;
               data_out_in  = ~item.tx_byte;
               phase_in     = PH_SEND_NRFD;
            end
            OP_RECEIVE: phase_in = PH_RECV;
            OP_ACK: begin
               drv_in[DR_NRFD] = 1'b1;
               drv_in[DR_NDAC] = 1'b0;
               phase_in        = PH_ACK;
            end
            OP_ADDRESS: phase_in = PH_ADDR;
            OP_ACCEPT: begin
               drv_in[DR_NDAC] = 1'b0;
               phase_in        = PH_ACCEPT;
            end
            OP_REJECT: begin
               drv_in     = '0;
               data_oe_in = 1'b0;
               unl_in     = 1'b1;
               phase_in   = PH_REJECT;
            end
            OP_BEGIN_OUT: begin
               drv_in[DR_NRFD] = 1'b0;
               phase_in        = PH_BOUT_ATN;
            end
            OP_END_OUT: begin
               drv_in     = '0;
               drv_in[DR_NDAC] = 1'b1;
               data_oe_in = 1'b0;
               status     = ST_DONE;
            end
            OP_UNLISTEN: begin
               drv_in     = '0;
               data_oe_in = 1'b0;
               unl_in     = 1'b1;
               status     = ST_DONE;
            end
            default: ;
         endcase
      end

      // bounded wait check, counter saturates
      expired   = CMP_WIDTH'(wait_in) > CMP_WIDTH'(timeout_ticks);
      wait_bump = (wait_in < COUNT_MAX) ? COUNT_WIDTH'(wait_in + 1'b1) : wait_in;

      if (phase_in != PH_IDLE) begin
         status = ST_BUSY;
         case (phase_in)
            PH_SEND_NRFD: begin
               if (item.nrfd_line) begin
                  if (held_last_in) drv_in[DR_EOI] = 1'b1;
                  drv_in[DR_DAV] = 1'b1;
                  phase_in       = PH_SEND_NDAC;
               end else if (!expired) begin
                  wait_in = wait_bump;
               end else begin
                  drv_in = '0; data_oe_in = 1'b0; unl_in = 1'b1;
                  rx_in = 8'hFF; phase_in = PH_IDLE; status = ST_TIMEOUT;
               end
            end
            PH_SEND_NDAC: begin
               if (item.ndac_line) begin
                  drv_in[DR_DAV] = 1'b0;
                  drv_in[DR_EOI] = 1'b0;
                  phase_in       = PH_IDLE;
                  status         = ST_DONE;
               end
            end
            PH_RECV: begin
               if (!item.dav_line) begin
                  drv_in[DR_NDAC] = 1'b1;
                  drv_in[DR_NRFD] = 1'b1;
                  rx_in      = ~item.bus_data;
                  atn_low_in = ~item.atn_line;
                  eoi_low_in = ~item.eoi_line;
                  phase_in   = PH_IDLE;
                  status     = ST_DONE;
               end else if (!expired) begin
                  wait_in = wait_bump;
               end else begin
                  drv_in = '0; data_oe_in = 1'b0; unl_in = 1'b1;
                  rx_in = 8'hFF; phase_in = PH_IDLE; status = ST_TIMEOUT;
               end
            end
            PH_ACK, PH_REJECT: begin
               if ((phase_in == PH_ACK) ? item.dav_line : item.atn_line) begin
                  phase_in = PH_IDLE;
                  status   = ST_DONE;
               end else if (!expired) begin
                  wait_in = wait_bump;
               end else begin
                  drv_in = '0; data_oe_in = 1'b0; unl_in = 1'b1;
                  rx_in = 8'hFF; phase_in = PH_IDLE; status = ST_TIMEOUT;
               end
            end
            PH_ADDR: begin
               if (!item.dav_line) begin
                  rx_in           = ~item.bus_data;
                  drv_in[DR_NRFD] = 1'b1;
                  drv_in[DR_NDAC] = 1'b0;
                  phase_in        = PH_IDLE;
                  status          = ST_DONE;
               end else if (!expired) begin
                  wait_in = wait_bump;
               end else begin
                  drv_in = '0; data_oe_in = 1'b0; unl_in = 1'b1;
                  rx_in = 8'hFF; phase_in = PH_IDLE; status = ST_TIMEOUT;
               end
            end
            PH_ACCEPT: begin
               // a timeout here still finishes the accept
               if (item.dav_line || expired) begin
                  if (item.dav_line) begin
                     status = ST_DONE;
                  end else begin
                     drv_in = '0; data_oe_in = 1'b0;
                     rx_in = 8'hFF; status = ST_TIMEOUT;
                  end
                  drv_in[DR_NDAC] = 1'b1;
                  drv_in[DR_NRFD] = 1'b0;
                  unl_in          = 1'b0;
                  phase_in        = PH_IDLE;
               end else begin
                  wait_in = wait_bump;
               end
            end
            PH_BOUT_ATN: begin
               if (item.atn_line) begin
                  drv_in[DR_NDAC] = 1'b0;
                  drv_in[DR_DAV]  = 1'b0;
                  drv_in[DR_EOI]  = 1'b0;
                  data_oe_in      = 1'b1;
                  phase_in        = PH_BOUT_NDAC;
               end else if (!expired) begin
                  wait_in = wait_bump;
               end else begin
                  drv_in = '0; data_oe_in = 1'b0; unl_in = 1'b1;
                  rx_in = 8'hFF; phase_in = PH_IDLE; status = ST_TIMEOUT;
               end
            end
            PH_BOUT_NDAC: begin
               if (!item.ndac_line) begin
                  phase_in = PH_IDLE;
                  status   = ST_DONE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               status   = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         held_last_ff <= 1'b0;
         drv_ff       <= '0;
         data_out_ff  <= 8'hFF;
         data_oe_ff   <= 1'b0;
         rx_ff        <= '0;
         atn_low_ff   <= 1'b0;
         eoi_low_ff   <= 1'b0;
         unl_ff       <= 1'b1;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         held_last_ff <= held_last_in;
         drv_ff       <= drv_in;
         data_out_ff  <= data_out_in;
         data_oe_ff   <= data_oe_in;
         rx_ff        <= rx_in;
         atn_low_ff   <= atn_low_in;
         eoi_low_ff   <= eoi_low_in;
         unl_ff       <= unl_in;
      end
   end

   assign result.dav_pull_low      = drv_in[DR_DAV];
   assign result.nrfd_pull_low     = drv_in[DR_NRFD];
   assign result.ndac_pull_low     = drv_in[DR_NDAC];
   assign result.eoi_pull_low      = drv_in[DR_EOI];
   assign result.data_drive        = data_out_in;
   assign result.data_drive_enable = data_oe_in;
   assign result.status            = status;
   assign result.rx_byte           = rx_in;
   assign result.rx_atn_low        = atn_low_in;
   assign result.rx_eoi_low        = eoi_low_in;
   assign result.unlistened        = unl_in;

endmodule

>>> rtl/core/gpib_device_handshake.sv
// ----------------------------------------------------------------------------
// gpib_device_handshake
// Device-side three-wire bus handshake engine with stream ports.
// ----------------------------------------------------------------------------
// Each request beat is one sampled tick of the bus lines (DAV, NRFD, NDAC,
// ATN, EOI, data) together with a command; each request beat yields exactly
// one response beat with the line drives, status and latched receive data
// after that tick. Commands are taken only while the engine is idle and are
// otherwise ignored. A beat is registered on entry, then the state machine
// evaluates it into the response register, so one beat is accepted per clock
// unless rsp_tready stalls the response; the rate is set by the engine's
// state update. timeout_ticks is written through csr_wr_en/csr_wr_data; the
// user must write it only while no beat is in flight, unchecked by the block.
module gpib_device_handshake
   import gdh_pkg::*;
#(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_wr_en,
   input  logic [TIMEOUT_WIDTH-1:0] csr_wr_data,   // timeout_ticks

   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [7:0] tx_byte, [15:8] bus_data, [16] dav_line, [17] nrfd_line,
   // [18] ndac_line, [19] atn_line, [20] eoi_line, [23:21] zero
   input  logic [23:0]              req_tdata,
   input  logic [3:0]               req_tuser,     // [3:0] operation
   input  logic                     req_tlast,     // tx_last

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] dav_pull_low, [1] nrfd_pull_low, [2] ndac_pull_low,
   // [3] eoi_pull_low, [11:4] data_drive, [12] data_drive_enable,
   // [14:13] status, [22:15] rx_byte, [23] rx_atn_low, [24] rx_eoi_low,
   // [25] unlistened, [31:26] zero
   output logic [31:0]              rsp_tdata
);

   logic [TIMEOUT_WIDTH-1:0] timeout_ff;
   logic                     in_valid_ff;
   item_type                 in_item_ff, in_item_in;
   logic                     rsp_valid_ff;
   logic [31:0]              rsp_data_ff;
   logic                     advance;
   result_type               result;

   // engine steps when its input beat can land in the response register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_item_in = '{
      operation: req_tuser,
      tx_byte:   req_tdata[7:0],
      tx_last:   req_tlast,
      bus_data:  req_tdata[15:8],
      dav_line:  req_tdata[16],
      nrfd_line: req_tdata[17],
      ndac_line: req_tdata[18],
      atn_line:  req_tdata[19],
      eoi_line:  req_tdata[20]
   };

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   gdh_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ff),
      .result        (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {6'b0,
                         result.unlistened,
                         result.rx_eoi_low,
                         result.rx_atn_low,
                         result.rx_byte,
                         result.status,
                         result.data_drive_enable,
                         result.data_drive,
                         result.eoi_pull_low,
                         result.ndac_pull_low,
                         result.nrfd_pull_low,
                         result.dav_pull_low};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
